>>> rtl/tree_lca_binary_lifting_defines.svh
// Assertion macros for the tree_lca_binary_lifting RTL, used by tlb_control.
// No dependencies; expects signals named clock and reset in the using scope.
`ifndef TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`ifndef SYNTH
`define TLB_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tree_lca_binary_lifting assertion failed");
`define TLB_ASSERT_NR(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("tree_lca_binary_lifting assertion failed");
`else
`define TLB_ASSERT(lbl, prop)
`define TLB_ASSERT_NR(lbl, prop)
`endif
`endif

>>> rtl/tlb_pkg.sv
// Shared types and constants for the binary lifting LCA block.
// No dependencies.
package tlb_pkg;

   localparam int NODES_DEF  = 1024;
   localparam int LEVELS_DEF = 10;
   localparam int FIELD_W    = 10;
   localparam int CMD_K_W    = 4;
   localparam int CMD_V_W    = 16;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef logic [4:0] dp_op_type;
   localparam dp_op_type OP_NONE  = 5'd0;
   localparam dp_op_type OP_CLEAR = 5'd1;
   localparam dp_op_type OP_CAPT  = 5'd2;
   localparam dp_op_type OP_LOAD  = 5'd3;
   localparam dp_op_type OP_BRD1  = 5'd4;
   localparam dp_op_type OP_BRD2  = 5'd5;
   localparam dp_op_type OP_BWR   = 5'd6;
   localparam dp_op_type OP_DINIT = 5'd7;
   localparam dp_op_type OP_DRD   = 5'd8;
   localparam dp_op_type OP_DSTEP = 5'd9;
   localparam dp_op_type OP_DWR   = 5'd10;
   localparam dp_op_type OP_QDRD  = 5'd11;
   localparam dp_op_type OP_QSWAP = 5'd12;
   localparam dp_op_type OP_LRD   = 5'd13;
   localparam dp_op_type OP_LIFT  = 5'd14;
   localparam dp_op_type OP_PRD   = 5'd15;
   localparam dp_op_type OP_PSTEP = 5'd16;
   localparam dp_op_type OP_FRD   = 5'd17;
   localparam dp_op_type OP_FIN   = 5'd18;
   localparam dp_op_type OP_EMIT  = 5'd19;

   typedef struct packed {
      dp_op_type          op;
      logic [CMD_K_W-1:0] k;
      logic [CMD_V_W-1:0] v;
   } dp_cmd_type;

   typedef struct packed {
      logic load_ok;
      logic a_eq_b;
   } dp_status_type;

endpackage

>>> rtl/tlb_datapath.sv
// Datapath of the LCA block: ancestor and depth memories, node registers.
// Depends on tlb_pkg; driven by tlb_control through dp_cmd_type.
module tlb_datapath #(
   parameter int NODES  = tlb_pkg::NODES_DEF,
   parameter int LEVELS = tlb_pkg::LEVELS_DEF
) (
   input  logic                          clock,
   input  tlb_pkg::dp_cmd_type           cmd,
   output tlb_pkg::dp_status_type        status,
   input  logic [tlb_pkg::FIELD_W-1:0]   first_node,
   input  logic [tlb_pkg::FIELD_W-1:0]   second_node,
   output logic [tlb_pkg::FIELD_W-1:0]   ancestor_node
);
   localparam int NW = $clog2(NODES);
   localparam int DW = LEVELS + 1;
   localparam int AW = $clog2(LEVELS * NODES);
   localparam int FW = tlb_pkg::FIELD_W;

   logic [NW-1:0] anc_mem [LEVELS*NODES];
   logic [DW-1:0] dep_mem [NODES];

   logic [FW-1:0] fa_ff, fb_ff, out_ff;
   logic [NW-1:0] a_ff, b_ff, u_ff, rd_a_ff, rd_b_ff;
   logic [DW-1:0] d_ff, diff_ff, rdd_a_ff, rdd_b_ff;

   logic [AW-1:0] raddr_a, raddr_b, waddr;
   logic [NW-1:0] wdata, v_node, qa, qb;
   logic          we;
   logic [tlb_pkg::CMD_K_W-1:0] km1;
   logic [DW-1:0] diff_sh;

   function automatic logic [AW-1:0] mem_addr(input logic [tlb_pkg::CMD_K_W-1:0] k,
                                              input logic [NW-1:0] node);
      mem_addr = AW'(32'(k) * NODES + 32'(node));
   endfunction

   function automatic logic [NW-1:0] clamp(input logic [FW-1:0] f);
      clamp = (32'(f) < NODES) ? NW'(f) : '0;
   endfunction

   assign v_node  = NW'(cmd.v);
   assign km1     = cmd.k - 1'b1;
   assign qa      = clamp(fa_ff);
   assign qb      = clamp(fb_ff);
   assign diff_sh = diff_ff >> cmd.k;

   assign status = '{
      load_ok: (fa_ff != '0) && (32'(fa_ff) < NODES) && (32'(fb_ff) < NODES),
      a_eq_b:  (a_ff == b_ff)
   };
   assign ancestor_node  = out_ff;

   always_comb begin
      raddr_a = mem_addr(cmd.k, a_ff);
      raddr_b = mem_addr(cmd.k, b_ff);
      waddr   = mem_addr(cmd.k, v_node);
      wdata   = rd_a_ff;
      we      = 1'b0;
      unique case (cmd.op)
         tlb_pkg::OP_CLEAR: begin
            we    = 1'b1;
            waddr = mem_addr('0, v_node);
            wdata = '0;
         end
         tlb_pkg::OP_LOAD: begin
            we    = status.load_ok;
            waddr = mem_addr('0, NW'(fa_ff));
            wdata = NW'(fb_ff);
         end
         tlb_pkg::OP_BRD1: raddr_a = mem_addr(km1, v_node);
         tlb_pkg::OP_BRD2: raddr_a = mem_addr(km1, rd_a_ff);
         tlb_pkg::OP_BWR:  we = 1'b1;
         tlb_pkg::OP_DRD:  raddr_a = mem_addr(cmd.k, u_ff);
         tlb_pkg::OP_FRD:  raddr_a = mem_addr('0, a_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         anc_mem[waddr] <= wdata;
      end
      rd_a_ff <= anc_mem[raddr_a];
      rd_b_ff <= anc_mem[raddr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tlb_pkg::OP_DWR) begin
         dep_mem[v_node] <= d_ff + DW'(u_ff != '0);
      end
      rdd_a_ff <= dep_mem[qa];
      rdd_b_ff <= dep_mem[qb];
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         tlb_pkg::OP_CAPT: begin
            fa_ff <= first_node;
            fb_ff <= second_node;
         end
         tlb_pkg::OP_DINIT: begin
            u_ff <= v_node;
            d_ff <= '0;
         end
         tlb_pkg::OP_DSTEP: begin
            if (rd_a_ff != '0) begin
               u_ff <= rd_a_ff;
               d_ff <= d_ff + (DW'(1) << cmd.k);
            end
         end
         tlb_pkg::OP_QDRD: begin
            a_ff <= qa;
            b_ff <= qb;
         end
         tlb_pkg::OP_QSWAP: begin
            // keep the deeper node in a
            if (rdd_b_ff > rdd_a_ff) begin
               a_ff    <= b_ff;
               b_ff    <= a_ff;
               diff_ff <= rdd_b_ff - rdd_a_ff;
            end else begin
               diff_ff <= rdd_a_ff - rdd_b_ff;
            end
         end
         tlb_pkg::OP_LIFT: begin
            if (diff_sh[0]) begin
               a_ff <= rd_a_ff;
            end
         end
         tlb_pkg::OP_PSTEP: begin
            if (rd_a_ff != rd_b_ff) begin
               a_ff <= rd_a_ff;
               b_ff <= rd_b_ff;
            end
         end
         tlb_pkg::OP_FIN:  a_ff <= rd_a_ff;
         tlb_pkg::OP_EMIT: out_ff <= FW'(32'(a_ff));
         default: ;
      endcase
   end

endmodule

>>> rtl/tlb_control.sv
// Controller of the LCA block: clear, load, rebuild and query sequencing.
// Depends on tlb_pkg and tree_lca_binary_lifting_defines.svh.
`include "tree_lca_binary_lifting_defines.svh"
module tlb_control #(
   parameter int NODES  = tlb_pkg::NODES_DEF,
   parameter int LEVELS = tlb_pkg::LEVELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tlb_pkg::dp_cmd_type    cmd,
   input  tlb_pkg::dp_status_type status
);
   localparam int NW = $clog2(NODES);
   localparam int KW = tlb_pkg::CMD_K_W;
   localparam int VW = tlb_pkg::CMD_V_W;

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_LOAD  = 5'd2;
   localparam logic [4:0] S_BRD1  = 5'd3;
   localparam logic [4:0] S_BRD2  = 5'd4;
   localparam logic [4:0] S_BWR   = 5'd5;
   localparam logic [4:0] S_DINIT = 5'd6;
   localparam logic [4:0] S_DRD   = 5'd7;
   localparam logic [4:0] S_DSTEP = 5'd8;
   localparam logic [4:0] S_DWR   = 5'd9;
   localparam logic [4:0] S_QDRD  = 5'd10;
   localparam logic [4:0] S_QSWAP = 5'd11;
   localparam logic [4:0] S_LRD   = 5'd12;
   localparam logic [4:0] S_LIFT  = 5'd13;
   localparam logic [4:0] S_PCHK  = 5'd14;
   localparam logic [4:0] S_PRD   = 5'd15;
   localparam logic [4:0] S_PSTEP = 5'd16;
   localparam logic [4:0] S_FRD   = 5'd17;
   localparam logic [4:0] S_FIN   = 5'd18;
   localparam logic [4:0] S_EMIT  = 5'd19;

   localparam logic [KW-1:0] K_TOP  = KW'(LEVELS - 1);
   localparam logic [NW-1:0] V_LAST = NW'(NODES - 1);

   logic [4:0]    state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [NW-1:0] v_ff, v_in;
   logic          stale_ff, stale_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, emit_ok;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      v_in         = v_ff;
      stale_in     = stale_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = tlb_pkg::OP_NONE;
      cmd.k        = k_ff;
      cmd.v        = VW'(32'(v_ff));
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = tlb_pkg::OP_CLEAR;
            v_in   = v_ff + 1'b1;
            if (v_ff == V_LAST) begin
               v_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.op = tlb_pkg::OP_CAPT;
               v_in   = '0;
               if (req_tuser == tlb_pkg::REQ_LOAD) begin
                  state_in = S_LOAD;
               end else if (!stale_ff) begin
                  state_in = S_QDRD;
               end else if (LEVELS > 1) begin
                  k_in     = KW'(1);
                  state_in = S_BRD1;
               end else begin
                  state_in = S_DINIT;
               end
            end
         end
         S_LOAD: begin
            cmd.op = tlb_pkg::OP_LOAD;
            if (status.load_ok) begin
               stale_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_BRD1: begin
            cmd.op   = tlb_pkg::OP_BRD1;
            state_in = S_BRD2;
         end
         S_BRD2: begin
            cmd.op   = tlb_pkg::OP_BRD2;
            state_in = S_BWR;
         end
         S_BWR: begin
            cmd.op   = tlb_pkg::OP_BWR;
            v_in     = v_ff + 1'b1;
            state_in = S_BRD1;
            if (v_ff == V_LAST) begin
               v_in = '0;
               if (k_ff == K_TOP) begin
                  state_in = S_DINIT;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_DINIT: begin
            cmd.op   = tlb_pkg::OP_DINIT;
            k_in     = K_TOP;
            state_in = S_DRD;
         end
         S_DRD: begin
            cmd.op   = tlb_pkg::OP_DRD;
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op = tlb_pkg::OP_DSTEP;
            if (k_ff == '0) begin
               state_in = S_DWR;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_DRD;
            end
         end
         S_DWR: begin
            cmd.op = tlb_pkg::OP_DWR;
            v_in   = v_ff + 1'b1;
            state_in = S_DINIT;
            if (v_ff == V_LAST) begin
               v_in     = '0;
               stale_in = 1'b0;
               state_in = S_QDRD;
            end
         end
         S_QDRD: begin
            cmd.op   = tlb_pkg::OP_QDRD;
            state_in = S_QSWAP;
         end
         S_QSWAP: begin
            cmd.op   = tlb_pkg::OP_QSWAP;
            k_in     = K_TOP;
            state_in = S_LRD;
         end
         S_LRD: begin
            cmd.op   = tlb_pkg::OP_LRD;
            state_in = S_LIFT;
         end
         S_LIFT: begin
            cmd.op = tlb_pkg::OP_LIFT;
            if (k_ff == '0) begin
               state_in = S_PCHK;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_LRD;
            end
         end
         S_PCHK: begin
            // equal after leveling: the deeper node sat under the other
            k_in     = K_TOP;
            state_in = status.a_eq_b ? S_EMIT : S_PRD;
         end
         S_PRD: begin
            cmd.op   = tlb_pkg::OP_PRD;
            state_in = S_PSTEP;
         end
         S_PSTEP: begin
            cmd.op = tlb_pkg::OP_PSTEP;
            if (k_ff == '0) begin
               state_in = S_FRD;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_PRD;
            end
         end
         S_FRD: begin
            cmd.op   = tlb_pkg::OP_FRD;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = tlb_pkg::OP_FIN;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_ok) begin
               cmd.op       = tlb_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         k_ff         <= '0;
         v_ff         <= '0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         v_ff         <= v_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TLB_ASSERT_NR(a_reset_clears, $past(reset) |-> (state_ff == S_CLEAR && stale_ff))
   `TLB_ASSERT(a_stale_rebuilds,
      (accept && req_tuser == tlb_pkg::REQ_QUERY && stale_ff)
         |=> (state_ff == S_BRD1 || state_ff == S_DINIT))
   `TLB_ASSERT(a_emit_valid, (state_ff == S_EMIT && emit_ok) |=> rsp_valid_ff)
   `TLB_ASSERT(a_build_done, (state_ff == S_DWR && v_ff == V_LAST) |=> !stale_ff)

endmodule

>>> rtl/tree_lca_binary_lifting.sv
// Lowest common ancestor over a rooted tree (root node 0) by binary lifting.
// After reset the parent table is cleared, with no request accepted. The
// first query after reset or after a valid load rebuilds the tables: the
// doubling pass and then the depth pass, both walking chains of dependent
// ancestor memory reads. A query then lifts the deeper node to the depth of
// the other and lifts both together level by level from the top level down.
// One item at a time; the result register lets the next request enter while
// a result waits.
module tree_lca_binary_lifting #(
   parameter int NODES  = tlb_pkg::NODES_DEF,
   parameter int LEVELS = tlb_pkg::LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [9:0] first_node, [19:10] second_node, [23:20] zero
   input  logic        req_tuser,  // [0] req_type: 0 load, 1 query
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [9:0] ancestor_node, [15:10] zero
);
   tlb_pkg::dp_cmd_type    cmd;
   tlb_pkg::dp_status_type status;
   logic [tlb_pkg::FIELD_W-1:0] ancestor_node;

   tlb_control #(.NODES(NODES), .LEVELS(LEVELS)) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tlb_datapath #(.NODES(NODES), .LEVELS(LEVELS)) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .first_node    (req_tdata[9:0]),
      .second_node   (req_tdata[19:10]),
      .ancestor_node (ancestor_node)
   );

   assign rsp_tdata = {6'b0, ancestor_node};

endmodule
